/* sv/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by the top level, the checker and the testbench.
package lpht_pkg;

    localparam int KEY_W        = 16;
    localparam int NAME_W       = 64;
    localparam int GRADE_W      = 8;
    localparam int SLOT_W       = 4;
    localparam int STATUS_W     = 3;
    localparam int DEF_TABLE_SIZE = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_HOME  = 3'd0,
        ST_COLL  = 3'd1,
        ST_FULL  = 3'd2,
        ST_FOUND = 3'd3,
        ST_MISS  = 3'd4
    } t_status;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [NAME_W-1:0]  name_word;
        logic [GRADE_W-1:0] grade;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [NAME_W-1:0]  found_name;
        logic [GRADE_W-1:0] found_grade;
    } t_out;

endpackage

/* sv/linear_probe_hash_table_top.sv */
// Steps from the start beat to the result strobe: the reciprocal key modulo (S_MUL,
// S_MOD), then one table read per cycle around the circle (S_PROBE), plus an extra
// write state (S_MOVE) when a misplaced resident is moved.
// Throughput: one item at a time; the next start is taken in the cycle the result shows.
// Reset: synchronous, then a clearing pass over the table memory with busy high.
// The receiver cannot stall; each result beat lasts exactly one cycle.
// Depends on lpht_pkg.
module linear_probe_hash_table_top #(
    parameter int TABLE_SIZE = lpht_pkg::DEF_TABLE_SIZE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lpht_pkg::t_in i_item,
    output logic          o_valid,
    output lpht_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import lpht_pkg::*;

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam logic [IW:0]    N_EXT = (IW+1)'(TABLE_SIZE);
    localparam logic [IW-1:0]  LAST  = IW'(TABLE_SIZE - 1);
    // floor(2^32 / TABLE_SIZE); quotient estimate is low by at most one
    localparam logic [31:0]       RECIP = 32'((64'd1 << 32) / TABLE_SIZE);
    localparam logic [KEY_W-1:0]  N_KEY = KEY_W'(TABLE_SIZE);

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [IW-1:0]      home;
        logic [NAME_W-1:0]  name;
        logic [GRADE_W-1:0] grade;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MOD,
        S_PROBE,
        S_MOVE
    } t_state;

    t_state r_state;
    logic   r_replace;

    // latched request
    logic               r_search;
    logic [KEY_W-1:0]   r_key;
    logic [NAME_W-1:0]  r_name;
    logic [GRADE_W-1:0] r_grade;

    // modulo unit
    logic [KEY_W+31:0] mul_full;
    logic [KEY_W-1:0]  r_qest;
    logic [KEY_W-1:0]  rem_est;
    logic [KEY_W-1:0]  rem_fix;

    // probe
    logic [IW-1:0] r_home;
    logic [IW-1:0] r_raddr;
    logic [IW-1:0] n_raddr;
    logic [IW:0]   r_iss;
    logic          r_pend;
    logic [IW-1:0] r_pend_n;
    logic [IW-1:0] r_paddr;
    t_entry        r_home_ent;
    t_entry        r_rdata;
    logic          pend_hit;
    logic          do_move;
    logic          n_valid;

    // memory
    t_entry        mem [TABLE_SIZE];
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        new_ent;

    assign busy = (r_state != S_IDLE);

    assign mul_full = r_key * RECIP;
    assign rem_est  = r_key - r_qest * N_KEY;
    assign rem_fix  = (rem_est >= N_KEY) ? (rem_est - N_KEY) : rem_est;

    assign n_raddr = (r_raddr == LAST) ? '0 : r_raddr + 1'b1;

    assign pend_hit = r_pend && (r_search ? (r_rdata.valid && r_rdata.key == r_key)
                                          : !r_rdata.valid);
    // home entry is valid whenever a free slot shows up past home
    assign do_move  = r_replace && (r_home_ent.home != r_home);

    assign n_valid = (r_state == S_MOVE) ||
                     ((r_state == S_PROBE) &&
                      ((pend_hit && (r_search || r_pend_n == '0 || !do_move)) ||
                       (!pend_hit && r_pend && r_pend_n == LAST)));

    always_comb begin
        new_ent.valid = 1'b1;
        new_ent.key   = r_key;
        new_ent.home  = r_home;
        new_ent.name  = r_name;
        new_ent.grade = r_grade;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_paddr;
        wr_data = new_ent;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_raddr;
                wr_data = '0;
            end
            S_PROBE: begin
                if (pend_hit && !r_search) begin
                    wr_en = 1'b1;
                    if (r_pend_n != '0 && do_move) begin
                        wr_data = r_home_ent;
                    end
                end
            end
            S_MOVE: begin
                wr_en   = 1'b1;
                wr_addr = r_home;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_replace <= 1'b0;
            r_raddr   <= '0;
            r_pend    <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= n_valid;
            if (i_cfg_we) begin
                r_replace <= i_cfg_wdata;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_raddr <= n_raddr;
                    if (r_raddr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_search <= (i_item.kind == KIND_SEARCH);
                        r_key    <= i_item.key;
                        r_name   <= i_item.name_word;
                        r_grade  <= i_item.grade;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_qest  <= mul_full[KEY_W+31:32];
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_home  <= rem_fix[IW-1:0];
                    r_raddr <= rem_fix[IW-1:0];
                    r_iss   <= '0;
                    r_pend  <= 1'b0;
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    // reads go out one per cycle; each check works on the registered read data in r_rdata
                    if (r_iss != N_EXT) begin
                        r_raddr  <= n_raddr;
                        r_iss    <= r_iss + 1'b1;
                        r_pend   <= 1'b1;
                        r_pend_n <= r_iss[IW-1:0];
                        r_paddr  <= r_raddr;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend && r_pend_n == '0) begin
                        r_home_ent <= r_rdata;
                    end
                    if (pend_hit) begin
                        if (r_search) begin
                            o_result.status      <= ST_FOUND;
                            o_result.slot        <= SLOT_W'(r_paddr);
                            o_result.found_name  <= r_rdata.name;
                            o_result.found_grade <= r_rdata.grade;
                            r_state              <= S_IDLE;
                        end else if (r_pend_n == '0) begin
                            o_result.status      <= ST_HOME;
                            o_result.slot        <= SLOT_W'(r_home);
                            o_result.found_name  <= '0;
                            o_result.found_grade <= '0;
                            r_state              <= S_IDLE;
                        end else if (do_move) begin
                            r_state <= S_MOVE;
                        end else begin
                            o_result.status      <= ST_COLL;
                            o_result.slot        <= SLOT_W'(r_paddr);
                            o_result.found_name  <= '0;
                            o_result.found_grade <= '0;
                            r_state              <= S_IDLE;
                        end
                    end else if (r_pend && r_pend_n == LAST) begin
                        o_result.status      <= r_search ? ST_MISS : ST_FULL;
                        o_result.slot        <= '0;
                        o_result.found_name  <= '0;
                        o_result.found_grade <= '0;
                        r_state              <= S_IDLE;
                    end
                end
                S_MOVE: begin
                    o_result.status      <= ST_COLL;
                    o_result.slot        <= SLOT_W'(r_home);
                    o_result.found_name  <= '0;
                    o_result.found_grade <= '0;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/lpht_checker.sv */
// Port-level checks for the hash table top level, plus the bind that attaches them.
// Depends on lpht_pkg and linear_probe_hash_table_top.
module lpht_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input lpht_pkg::t_out o_result
);
    import lpht_pkg::*;

    // reset starts the clearing pass, no stray result
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_valid)
        else $error("not busy after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted beat did not make block busy");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy ##1 !o_valid)
        else $error("result beat while busy or repeated");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == ST_FULL || o_result.status == ST_MISS)
        |-> o_result.slot == '0)
        else $error("slot not zero on full or miss");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status != ST_FOUND
        |-> o_result.found_name == '0 && o_result.found_grade == '0)
        else $error("record data on a non-hit result");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for linear_probe_hash_table_top: directed and random
// insert/search beats, checked against an in-bench copy of the table.
// Depends on lpht_pkg and linear_probe_hash_table_top.
`timescale 1ns / 1ps

module tb_top;
    import lpht_pkg::*;

    localparam int TBL          = DEF_TABLE_SIZE;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = TBL + 24;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic dut_start   = 1'b0;
    logic dut_busy;
    t_in  dut_item    = '0;
    logic dut_valid;
    t_out dut_result;
    logic cfg_we      = 1'b0;
    logic cfg_wdata   = 1'b0;

    // Shadow copy of the table and the replace register
    bit              shadow_valid [TBL];
    logic [KEY_W-1:0]   shadow_key   [TBL];
    logic [NAME_W-1:0]  shadow_name  [TBL];
    logic [GRADE_W-1:0] shadow_grade [TBL];
    bit              shadow_replace = 1'b0;

    t_in  pending_items [$];
    t_out expected_results [$];
    int   send_idle_pct  = 20;
    int   mismatch_count = 0;
    int   stall_cycles   = 0;

    always #1 i_clk = ~i_clk;

    linear_probe_hash_table_top #(.TABLE_SIZE(TBL)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (dut_start),
        .busy        (dut_busy),
        .i_item      (dut_item),
        .o_valid     (dut_valid),
        .o_result    (dut_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    function automatic void place_record(int idx, logic [KEY_W-1:0] k,
                                         logic [NAME_W-1:0] nm, logic [GRADE_W-1:0] g);
        shadow_valid[idx] = 1'b1;
        shadow_key[idx]   = k;
        shadow_name[idx]  = nm;
        shadow_grade[idx] = g;
    endfunction

    // Applies one insert or search to the shadow table, returns the result beat
    function automatic t_out apply_table_op(t_in it);
        t_out r;
        int   home;
        int   idx;
        int   free_idx;
        bit   hit;
        r    = '0;
        home = int'(it.key) % TBL;
        if (it.kind == KIND_SEARCH) begin
            r.status = ST_MISS;
            hit = 1'b0;
            for (int n = 0; n < TBL; n++) begin
                idx = (home + n) % TBL;
                if (!hit && shadow_valid[idx] && shadow_key[idx] == it.key) begin
                    hit           = 1'b1;
                    r.status      = ST_FOUND;
                    r.slot        = SLOT_W'(idx);
                    r.found_name  = shadow_name[idx];
                    r.found_grade = shadow_grade[idx];
                end
            end
        end else if (!shadow_valid[home]) begin
            place_record(home, it.key, it.name_word, it.grade);
            r.status = ST_HOME;
            r.slot   = SLOT_W'(home);
        end else begin
            free_idx = -1;
            for (int n = 1; n < TBL; n++) begin
                idx = (home + n) % TBL;
                if (free_idx < 0 && !shadow_valid[idx])
                    free_idx = idx;
            end
            if (free_idx < 0) begin
                r.status = ST_FULL;
            end else if (shadow_replace && (int'(shadow_key[home]) % TBL) != home) begin
                // misplaced resident moves out, new record takes its home
                place_record(free_idx, shadow_key[home], shadow_name[home],
                             shadow_grade[home]);
                place_record(home, it.key, it.name_word, it.grade);
                r.status = ST_COLL;
                r.slot   = SLOT_W'(home);
            end else begin
                place_record(free_idx, it.key, it.name_word, it.grade);
                r.status = ST_COLL;
                r.slot   = SLOT_W'(free_idx);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < 40)
            $display("mismatch @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Driver: one beat per start/!busy edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dut_start <= 1'b0;
        end else begin
            if (dut_start && !dut_busy)
                expected_results.push_back(apply_table_op(dut_item));
            if (!(dut_start && dut_busy)) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    dut_start <= 1'b1;
                    dut_item  <= pending_items.pop_front();
                end else begin
                    dut_start <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && dut_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = expected_results.pop_front();
                if (dut_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              dut_result.status, want.status));
                if (dut_result.slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, want %0d",
                                              dut_result.slot, want.slot));
                if (dut_result.found_name !== want.found_name)
                    report_mismatch($sformatf("found_name %h, want %h",
                                              dut_result.found_name, want.found_name));
                if (dut_result.found_grade !== want.found_grade)
                    report_mismatch($sformatf("found_grade %h, want %h",
                                              dut_result.found_grade, want.found_grade));
            end
        end
    end

    // Watchdog: cycles with no accepted beat on either side
    always @(posedge i_clk) begin
        if ((dut_start && !dut_busy) || dut_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_item(t_kind kind, logic [KEY_W-1:0] key,
                              logic [NAME_W-1:0] nm, logic [GRADE_W-1:0] g);
        t_in it;
        it.kind      = kind;
        it.key       = key;
        it.name_word = nm;
        it.grade     = g;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_items.size() > 0 || dut_start || expected_results.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_replace_mode(bit v);
        wait_drained();
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        shadow_replace = v;
    endtask

    function automatic logic [NAME_W-1:0] rand_name();
        return {$urandom, $urandom};
    endfunction

    // Mostly keys already resident (hits and same-home neighbors), some fully random
    function automatic logic [KEY_W-1:0] pick_key();
        int idx;
        int sel;
        idx = $urandom_range(0, TBL - 1);
        sel = $urandom_range(0, 99);
        if (sel < 55 && shadow_valid[idx])
            return shadow_key[idx];
        if (sel < 70 && shadow_valid[idx])
            return shadow_key[idx] + KEY_W'(TBL * $urandom_range(1, 3));
        return KEY_W'($urandom_range(0, 65535));
    endfunction

    task automatic run_random(int count, int idle_pct);
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            @(negedge i_clk);
            while (pending_items.size() > 1)
                @(negedge i_clk);
            queue_item(($urandom_range(0, 99) < 35) ? KIND_INSERT : KIND_SEARCH,
                       pick_key(), rand_name(), GRADE_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no replacement
        write_replace_mode(1'b0);
        queue_item(KIND_INSERT, 16'h0000, 64'h0, 8'h00);
        queue_item(KIND_INSERT, 16'hFFFF, '1, 8'hFF);
        queue_item(KIND_INSERT, 16'h0010, 64'h0123_4567_89AB_CDEF, 8'h41);
        queue_item(KIND_INSERT, 16'h001F, 64'hFEDC_BA98_7654_3210, 8'h42); // wraps
        queue_item(KIND_SEARCH, 16'h0010, '1, 8'hFF);
        queue_item(KIND_SEARCH, 16'h0000, 64'h0, 8'h00);
        queue_item(KIND_SEARCH, 16'h1234, rand_name(), 8'h5A);            // miss
        queue_item(KIND_INSERT, 16'h0000, 64'hAAAA_5555_AAAA_5555, 8'h43); // duplicate
        queue_item(KIND_SEARCH, 16'h0000, 64'h0, 8'h00);

        // Directed: replacement of misplaced residents
        write_replace_mode(1'b1);
        queue_item(KIND_INSERT, 16'h0002, 64'h5555_AAAA_5555_AAAA, 8'h44);
        queue_item(KIND_INSERT, 16'h0011, rand_name(), 8'h45);
        queue_item(KIND_INSERT, 16'h0005, rand_name(), 8'h46);
        queue_item(KIND_INSERT, 16'h0020, rand_name(), 8'h47); // resident at own home
        queue_item(KIND_SEARCH, 16'h001F, rand_name(), 8'hA5);
        queue_item(KIND_SEARCH, 16'h0010, rand_name(), 8'h3C);
        queue_item(KIND_INSERT, 16'h0008, rand_name(), 8'h80);

        // Fill the remaining slots from one home, then hit a full table
        write_replace_mode(1'b0);
        for (int n = 0; n < 6; n++)
            queue_item(KIND_INSERT, KEY_W'(16'h0009 + 16 * n), rand_name(),
                       GRADE_W'($urandom_range(0, 255)));
        queue_item(KIND_INSERT, 16'h1000, rand_name(), 8'h01);
        write_replace_mode(1'b1);
        queue_item(KIND_INSERT, 16'h0003, rand_name(), 8'h02);   // full, resident misplaced
        queue_item(KIND_SEARCH, 16'h0059, 64'h0, 8'h00);
        queue_item(KIND_SEARCH, 16'hFFFF, 64'h0, 8'h00);

        // Random
        write_replace_mode(1'b0);
        run_random(280, 20);
        write_replace_mode(1'b1);
        run_random(280, 65);
        write_replace_mode(1'b0);
        run_random(150, 0);
        write_replace_mode(1'b1);
        run_random(140, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
